>>> rtl/core/sgm_pkg.sv
// Shared types, constants and tables for the spectral gain mask generator.
`default_nettype none
package sgm_pkg;

   localparam int MAX_BINS     = 4096;
   localparam int BIN_W        = 12;
   localparam int CNT_W        = 13;
   localparam int GAIN_W       = 16;
   localparam int D_W          = 14;
   localparam int XY_W         = 32;
   localparam int Z_W          = 26;
   localparam int TAB_W        = 23;
   localparam int CORDIC_STEPS = 18;
   localparam int EDGE_LAT     = CORDIC_STEPS + 1;
   localparam int ADDR_W       = 5;
   localparam int DATA_W       = 32;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;
   localparam logic [GAIN_W-1:0] HALF_GAIN  = 16'd16384;
   localparam logic [GAIN_W-1:0] ZERO_GAIN  = 16'd0;

   // atan(2^-k)/pi in units of 2^-24
   localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
      23'd83436, 23'd41721, 23'd20861, 23'd10430, 23'd5215, 23'd2608,
      23'd1304, 23'd652, 23'd326, 23'd163, 23'd81, 23'd41
   };

   typedef enum logic [1:0] {
      FT_LOWPASS,
      FT_HIGHPASS,
      FT_BANDPASS,
      FT_RESERVED
   } filter_type_type;

   typedef enum logic [1:0] {
      SYM_MIRROR,
      SYM_RIGHT,
      SYM_LEFT,
      SYM_RESERVED
   } symmetry_type;

   typedef enum logic [2:0] {
      REG_FILTER_TYPE,
      REG_BIN_COUNT,
      REG_CUTOFF_BIN,
      REG_EDGE_ORDER,
      REG_BAND_WIDTH,
      REG_SYMMETRY_MODE,
      REG_INVERT_GAIN,
      REG_FILTER_ACTIVE
   } reg_index_type;

   typedef enum logic [1:0] {
      GM_CONST,
      GM_EDGE,
      GM_BAND
   } gain_mode_type;

   typedef struct packed {
      filter_type_type   filter_type;
      logic [CNT_W-1:0]  bin_count;
      logic [BIN_W-1:0]  cutoff_bin;
      logic [CNT_W-1:0]  edge_order;
      logic [CNT_W-1:0]  band_width;
      symmetry_type      symmetry_mode;
      logic              invert_gain;
      logic              filter_active;
   } cfg_type;

   typedef struct packed {
      logic [BIN_W-1:0]  bin_index;
      gain_mode_type     mode;
      logic [GAIN_W-1:0] const_gain;
      logic              apply_inv;
   } side_type;

endpackage
`default_nettype wire

>>> rtl/core/spectral_gain_mask_generator.sv
// Pipeline: 2 front stages, 19 CORDIC stages, product stage and output register
// from request transaction to response; stalls hold every stage.
// Throughput: one bin per cycle; the whole pipeline advances together and
// holds while the output register waits for rsp_ready.
// Reset: synchronous; clears valid bits and loads register defaults.
// Top level of the spectral gain mask generator.
`default_nettype none
module spectral_gain_mask_generator
   import sgm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BIN_W-1:0]  req_bin_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [GAIN_W-1:0]      rsp_gain_value,
   output logic [BIN_W-1:0]       rsp_bin_index_out
);

   cfg_type               cfg;
   logic                  en;
   logic                  f_vld;
   side_type              f_side;
   logic signed [D_W-1:0] f_d1;
   logic signed [D_W-1:0] f_d2;
   logic [GAIN_W-1:0]     e1;
   logic [GAIN_W-1:0]     e2;

   logic                  vld_dly_ff  [EDGE_LAT];
   side_type              side_dly_ff [EDGE_LAT];
   side_type              side_last;

   logic [31:0]           prod;
   logic [31:0]           prod_r;
   logic [GAIN_W-1:0]     g_in;
   logic                  p_vld_ff;
   logic [GAIN_W-1:0]     p_gain_ff;
   logic [BIN_W-1:0]      p_j_ff;
   logic                  p_inv_ff;

   logic                  rsp_valid_ff;
   logic [GAIN_W-1:0]     rsp_gain_ff;
   logic [BIN_W-1:0]      rsp_j_ff;

   // advance everything unless the output holds an untaken transaction
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   sgm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sgm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cfg          (cfg),
      .in_valid     (req_valid),
      .in_bin_index (req_bin_index),
      .out_valid    (f_vld),
      .out_side     (f_side),
      .out_d1       (f_d1),
      .out_d2       (f_d2)
   );

   sgm_cordic u_edge_hi (
      .clock (clock),
      .en    (en),
      .d_in  (f_d1),
      .order (cfg.edge_order),
      .e_out (e1)
   );

   sgm_cordic u_edge_lo (
      .clock (clock),
      .en    (en),
      .d_in  (f_d2),
      .order (cfg.edge_order),
      .e_out (e2)
   );

   for (genvar k = 0; k < EDGE_LAT; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_dly_ff[k] <= 1'b0;
         end else if (en) begin
            vld_dly_ff[k] <= (k == 0) ? f_vld : vld_dly_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_dly_ff[k] <= (k == 0) ? f_side : side_dly_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign side_last = side_dly_ff[EDGE_LAT-1];

   // edge gain, band-pass product of the high and low edge gains rounded back to Q1.15, or constant gain
   always_comb begin
      prod   = e1 * e2;
      prod_r = prod + 32'd16384;
      case (side_last.mode)
         GM_EDGE: g_in = e1;
         GM_BAND: g_in = prod_r[30:15];
         default: g_in = side_last.const_gain;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff     <= vld_dly_ff[EDGE_LAT-1];
         rsp_valid_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_gain_ff   <= g_in;
         p_j_ff      <= side_last.bin_index;
         p_inv_ff    <= side_last.apply_inv;
         rsp_gain_ff <= p_inv_ff ? (UNITY_GAIN - p_gain_ff) : p_gain_ff;
         rsp_j_ff    <= p_j_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gain_value    = rsp_gain_ff;
   assign rsp_bin_index_out = rsp_j_ff;

`ifndef SYNTHESIS
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain_value <= UNITY_GAIN))
      else $error("gain above unity");
   a_inactive_unity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cfg.filter_active) |-> (rsp_gain_value == UNITY_GAIN))
      else $error("inactive mask gives non-unity gain");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (p_vld_ff && rsp_valid && !rsp_ready) |=> p_vld_ff)
      else $error("pipeline transaction lost during stall");
`endif

endmodule
`default_nettype wire

>>> rtl/core/sgm_csr.sv
// Configuration register bank with APB-style access.
`default_nettype none
module sgm_csr
   import sgm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_type   <= FT_LOWPASS;
         cfg_ff.bin_count     <= 13'd4096;
         cfg_ff.cutoff_bin    <= 12'd1024;
         cfg_ff.edge_order    <= 13'd256;
         cfg_ff.band_width    <= 13'd256;
         cfg_ff.symmetry_mode <= SYM_MIRROR;
         cfg_ff.invert_gain   <= 1'b0;
         cfg_ff.filter_active <= 1'b0;
      end else if (wr_en) begin
         unique case (idx)
            REG_FILTER_TYPE:   cfg_ff.filter_type   <= filter_type_type'(pwdata[1:0]);
            REG_BIN_COUNT:     cfg_ff.bin_count     <= pwdata[CNT_W-1:0];
            REG_CUTOFF_BIN:    cfg_ff.cutoff_bin    <= pwdata[BIN_W-1:0];
            REG_EDGE_ORDER:    cfg_ff.edge_order    <= pwdata[CNT_W-1:0];
            REG_BAND_WIDTH:    cfg_ff.band_width    <= pwdata[CNT_W-1:0];
            REG_SYMMETRY_MODE: cfg_ff.symmetry_mode <= symmetry_type'(pwdata[1:0]);
            REG_INVERT_GAIN:   cfg_ff.invert_gain   <= pwdata[0];
            REG_FILTER_ACTIVE: cfg_ff.filter_active <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_FILTER_TYPE:   prdata[1:0]       = cfg_ff.filter_type;
         REG_BIN_COUNT:     prdata[CNT_W-1:0] = cfg_ff.bin_count;
         REG_CUTOFF_BIN:    prdata[BIN_W-1:0] = cfg_ff.cutoff_bin;
         REG_EDGE_ORDER:    prdata[CNT_W-1:0] = cfg_ff.edge_order;
         REG_BAND_WIDTH:    prdata[CNT_W-1:0] = cfg_ff.band_width;
         REG_SYMMETRY_MODE: prdata[1:0]       = cfg_ff.symmetry_mode;
         REG_INVERT_GAIN:   prdata[0]         = cfg_ff.invert_gain;
         REG_FILTER_ACTIVE: prdata[0]         = cfg_ff.filter_active;
         default: prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/sgm_front.sv
// Front stages: bin mapping by symmetry, then edge distances and hard gains.
`default_nettype none
module sgm_front
   import sgm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire cfg_type            cfg,
   input  wire logic               in_valid,
   input  wire logic [BIN_W-1:0]   in_bin_index,
   output logic                    out_valid,
   output side_type                out_side,
   output logic signed [D_W-1:0]   out_d1,
   output logic signed [D_W-1:0]   out_d2
);

   logic [CNT_W-1:0] n;
   logic [BIN_W-1:0] half;
   logic [CNT_W-1:0] j13;
   logic [CNT_W-1:0] rev;
   logic [BIN_W-1:0] s_in;
   logic             pass_in;

   logic             a_vld_ff;
   logic [BIN_W-1:0] a_j_ff;
   logic [BIN_W-1:0] a_s_ff;
   logic             a_pass_ff;

   logic signed [14:0] fs, ss, hs, ws, lo, hi, lo_c, hi_c;
   logic signed [14:0] d1, d2;
   side_type           side_in;

   logic                  b_vld_ff;
   side_type              b_side_ff;
   logic signed [D_W-1:0] b_d1_ff;
   logic signed [D_W-1:0] b_d2_ff;

   assign n    = (cfg.bin_count > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : cfg.bin_count;
   assign half = n[CNT_W-1:1];

   // stage A: choose which base bin feeds this output bin
   always_comb begin
      j13     = {1'b0, in_bin_index};
      rev     = n - CNT_W'(1) - j13;
      pass_in = !cfg.filter_active || (j13 >= n);
      case (cfg.symmetry_mode)
         SYM_MIRROR: s_in = (j13 >= (n - {1'b0, half})) ? rev[BIN_W-1:0] : in_bin_index;
         SYM_RIGHT:  s_in = rev[BIN_W-1:0];
         default:    s_in = in_bin_index;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_j_ff    <= in_bin_index;
         a_s_ff    <= s_in;
         a_pass_ff <= pass_in;
      end
   end

   // stage B: edge distances and hard-step gains
   always_comb begin
      fs   = $signed({3'b000, cfg.cutoff_bin});
      ss   = $signed({3'b000, a_s_ff});
      hs   = $signed({3'b000, half});
      ws   = $signed({3'b000, cfg.band_width[CNT_W-1:1]});
      lo   = fs - ws;
      hi   = fs + ws;
      lo_c = (lo < 0) ? 15'sd0 : ((lo > hs) ? hs : lo);
      hi_c = (hi < 0) ? 15'sd0 : ((hi > hs) ? hs : hi);
      d1   = fs - ss;
      d2   = ss - lo_c;

      side_in.bin_index  = a_j_ff;
      side_in.mode       = GM_CONST;
      side_in.const_gain = UNITY_GAIN;
      side_in.apply_inv  = cfg.invert_gain;

      case (cfg.filter_type)
         FT_LOWPASS: begin
            if (ss < hs) begin
               d1 = fs - ss;
               if (cfg.edge_order == '0) begin
                  side_in.const_gain = (fs > ss) ? UNITY_GAIN : ZERO_GAIN;
               end else begin
                  side_in.mode = GM_EDGE;
               end
            end else begin
               d1 = fs + ss;
               if (cfg.edge_order != '0) begin
                  side_in.mode = GM_EDGE;
               end
            end
         end
         FT_HIGHPASS: begin
            d1 = ss - fs;
            if (cfg.edge_order == '0) begin
               side_in.const_gain = (ss >= fs) ? UNITY_GAIN : ZERO_GAIN;
            end else begin
               side_in.mode = GM_EDGE;
            end
         end
         FT_BANDPASS: begin
            d1 = hi_c - ss;
            if (ss < hs) begin
               if (cfg.edge_order == '0) begin
                  side_in.const_gain = (ss >= lo_c && ss < hi_c) ? UNITY_GAIN : ZERO_GAIN;
               end else begin
                  side_in.mode = GM_BAND;
               end
            end
         end
         default: ;
      endcase

      // inactive or out-of-range bins: unity, never inverted
      if (a_pass_ff) begin
         side_in.mode       = GM_CONST;
         side_in.const_gain = UNITY_GAIN;
         side_in.apply_inv  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_side_ff <= side_in;
         b_d1_ff   <= d1[D_W-1:0];
         b_d2_ff   <= d2[D_W-1:0];
      end
   end

   assign out_valid = b_vld_ff;
   assign out_side  = b_side_ff;
   assign out_d1    = b_d1_ff;
   assign out_d2    = b_d2_ff;

endmodule
`default_nettype wire

>>> rtl/core/sgm_cordic.sv
// Pipelined CORDIC soft edge: 0.5 + atan(d/order)/pi in Q1.15.
`default_nettype none
module sgm_cordic
   import sgm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [D_W-1:0] d_in,
   input  wire logic [CNT_W-1:0]    order,
   output logic [GAIN_W-1:0]        e_out
);

   logic signed [XY_W-1:0] x_src [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_src [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_src [CORDIC_STEPS];
   logic                   n_src [CORDIC_STEPS];
   logic signed [XY_W-1:0] x_ff  [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff  [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff  [CORDIC_STEPS];
   logic                   n_ff  [CORDIC_STEPS];

   logic signed [D_W-1:0]  mag_full;
   logic [CNT_W-1:0]       mag;
   logic signed [Z_W-1:0]  zc;
   logic signed [Z_W-1:0]  zr;
   logic [Z_W-10:0]        q;
   logic [GAIN_W-1:0]      qc;
   logic [GAIN_W-1:0]      e_in;
   logic [GAIN_W-1:0]      e_ff;

   assign mag_full = d_in[D_W-1] ? -d_in : d_in;
   assign mag      = mag_full[CNT_W-1:0];

   assign x_src[0] = $signed({3'b000, order, 16'h0000});
   assign y_src[0] = $signed({3'b000, mag, 16'h0000});
   assign z_src[0] = '0;
   assign n_src[0] = d_in[D_W-1];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [Z_W-1:0]  t;

      if (k > 0) begin : g_link
         assign x_src[k] = x_ff[k-1];
         assign y_src[k] = y_ff[k-1];
         assign z_src[k] = z_ff[k-1];
         assign n_src[k] = n_ff[k-1];
      end

      assign xs = x_src[k] >>> k;
      assign ys = y_src[k] >>> k;
      assign t  = $signed({3'b000, ATAN_TAB[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_src[k];
            if (!y_src[k][XY_W-1]) begin
               x_ff[k] <= x_src[k] + ys;
               y_ff[k] <= y_src[k] - xs;
               z_ff[k] <= z_src[k] + t;
            end else begin
               x_ff[k] <= x_src[k] - ys;
               y_ff[k] <= y_src[k] + xs;
               z_ff[k] <= z_src[k] - t;
            end
         end
      end
   end

   // round angle to Q1.15 half-turn units and fold in the sign
   always_comb begin
      zc   = z_ff[CORDIC_STEPS-1][Z_W-1] ? '0 : z_ff[CORDIC_STEPS-1];
      zr   = zc + Z_W'(256);
      q    = zr[Z_W-1:9];
      qc   = (q > (Z_W-9)'(16384)) ? HALF_GAIN : q[GAIN_W-1:0];
      e_in = n_ff[CORDIC_STEPS-1] ? (HALF_GAIN - qc) : (HALF_GAIN + qc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   assign e_out = e_ff;

`ifndef SYNTHESIS
   a_edge_range: assert property (@(posedge clock) !$isunknown(e_ff) |-> (e_ff <= UNITY_GAIN))
      else $error("edge gain above unity");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the spectral gain mask generator.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import sgm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BIN_W-1:0] req_bin_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [GAIN_W-1:0] rsp_gain_value;
   logic [BIN_W-1:0] rsp_bin_index_out;

   spectral_gain_mask_generator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the programmed mask settings
   filter_type_type m_type = FT_LOWPASS;
   int m_count = 4096, m_cutoff = 1024, m_order = 256, m_width = 256;
   symmetry_type m_sym = SYM_MIRROR;
   bit m_inv = 0, m_active = 0;

   typedef struct {
      logic [GAIN_W-1:0] gain;
      logic [BIN_W-1:0]  bin;
   } mask_entry_type;
   mask_entry_type pending_gains[$];

   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0;

   const longint ATAN_UNITS[18] = '{4194304, 2476042, 1308273, 664100, 333339, 166832,
      83436, 41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};

   function automatic longint arctan_edge(longint d, longint ord);
      longint mag, x, y, z, q, xs, ys;
      mag = d < 0 ? -d : d;
      x = ord * 65536;
      y = mag * 65536;
      z = 0;
      for (int k = 0; k < 18; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_UNITS[k];
         end else begin
            x -= ys; y += xs; z -= ATAN_UNITS[k];
         end
      end
      if (z < 0) z = 0;
      q = (z + 256) >>> 9;
      if (q > 16384) q = 16384;
      return d < 0 ? 16384 - q : 16384 + q;
   endfunction

   function automatic longint left_gain(longint j, longint n);
      longint h, f, o, lo, hi;
      h = n / 2; f = m_cutoff; o = m_order;
      case (m_type)
         FT_LOWPASS: begin
            if (j < h) return o == 0 ? ((f - j > 0) ? 32768 : 0) : arctan_edge(f - j, o);
            return o == 0 ? 32768 : arctan_edge(f + j, o);
         end
         FT_HIGHPASS:
            return o == 0 ? ((j - f >= 0) ? 32768 : 0) : arctan_edge(j - f, o);
         FT_BANDPASS: begin
            lo = f - m_width / 2;
            hi = f + m_width / 2;
            if (lo < 0) lo = 0;
            if (lo > h) lo = h;
            if (hi < 0) hi = 0;
            if (hi > h) hi = h;
            if (j >= h) return 32768;
            if (o == 0) return (j >= lo && j < hi) ? 32768 : 0;
            return (arctan_edge(hi - j, o) * arctan_edge(j - lo, o) + 16384) >>> 15;
         end
         default: return 32768;
      endcase
   endfunction

   function automatic longint bin_gain(longint j);
      longint n, s, g;
      n = m_count < MAX_BINS ? m_count : MAX_BINS;
      g = 32768;
      if (m_active && j < n) begin
         s = j;
         if (m_sym == SYM_MIRROR) begin
            if (j >= n - n / 2) s = n - 1 - j;
         end else if (m_sym == SYM_RIGHT) begin
            s = n - 1 - j;
         end
         g = left_gain(s, n);
         if (g < 0) g = 0;
         if (g > 32768) g = 32768;
         if (m_inv) g = 32768 - g;
      end
      return g;
   endfunction

   task automatic write_reg(reg_index_type idx, int value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_FILTER_TYPE:   m_type = filter_type_type'(value[1:0]);
         REG_BIN_COUNT:     m_count = value & 32'h1FFF;
         REG_CUTOFF_BIN:    m_cutoff = value & 32'hFFF;
         REG_EDGE_ORDER:    m_order = value & 32'h1FFF;
         REG_BAND_WIDTH:    m_width = value & 32'h1FFF;
         REG_SYMMETRY_MODE: m_sym = symmetry_type'(value[1:0]);
         REG_INVERT_GAIN:   m_inv = value[0];
         REG_FILTER_ACTIVE: m_active = value[0];
         default: ;
      endcase
   endtask

   task automatic set_mask(int ft, int n, int f, int o, int w, int sym, int inv, int act);
      req_valid <= 1'b0;
      // drain the pipe before touching any register
      while (pending_gains.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      write_reg(REG_FILTER_TYPE, ft);
      write_reg(REG_BIN_COUNT, n);
      write_reg(REG_CUTOFF_BIN, f);
      write_reg(REG_EDGE_ORDER, o);
      write_reg(REG_BAND_WIDTH, w);
      write_reg(REG_SYMMETRY_MODE, sym);
      write_reg(REG_INVERT_GAIN, inv);
      write_reg(REG_FILTER_ACTIVE, act);
   endtask

   // called at a falling edge; leaves req_valid high so the next call can follow at once
   task automatic send_bin(int bin);
      mask_entry_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_bin_index <= bin[BIN_W-1:0];
      e.gain = GAIN_W'(bin_gain(bin[BIN_W-1:0]));
      e.bin = bin[BIN_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_gains.push_back(e);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_ready <= $urandom_range(99) >= recv_idle_pct;

   always @(posedge clock) begin
      mask_entry_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_gains.size() == 0) begin
            $display("%0t: unexpected response gain %0d bin %0d", $time,
                     rsp_gain_value, rsp_bin_index_out);
            errors++;
         end else begin
            e = pending_gains.pop_front();
            if (rsp_gain_value !== e.gain) begin
               $display("%0t: gain mismatch bin %0d expected %0d actual %0d", $time,
                        e.bin, e.gain, rsp_gain_value);
               errors++;
            end
            if (rsp_bin_index_out !== e.bin) begin
               $display("%0t: bin mismatch expected %0d actual %0d", $time,
                        e.bin, rsp_bin_index_out);
               errors++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_bin(0); send_bin(4095); send_bin(1234);
      set_mask(0, 4096, 1024, 256, 256, 0, 0, 1);
      send_bin(0); send_bin(1023); send_bin(1024); send_bin(2048); send_bin(4095);
   endtask

   task automatic test_directed();
      set_mask(0, 16, 4, 0, 2, 2, 0, 1);   // hard low-pass step
      for (int b = 0; b < 17; b += 4) send_bin(b);
      send_bin(4095);                      // outside range
      set_mask(1, 16, 4, 0, 2, 1, 1, 1);   // hard high-pass, inverted, right
      send_bin(3); send_bin(12); send_bin(15);
      set_mask(2, 4, 1, 4096, 4096, 0, 0, 1);
      send_bin(0); send_bin(2); send_bin(3);
      set_mask(3, 4096, 2048, 1, 1, 3, 1, 1); // reserved type and symmetry
      send_bin(0); send_bin(2047);
      set_mask(0, 8191, 4095, 8191, 8191, 0, 0, 1); // cutoff beyond half
      send_bin(100); send_bin(4000);
   endtask

   task automatic test_random(int phases, int per_phase);
      int n;
      for (int p = 0; p < phases; p++) begin
         n = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(4, 64);
         set_mask($urandom_range(3), n, $urandom_range(4095),
                  ($urandom_range(3) == 0) ? 0 : $urandom_range(8191),
                  $urandom_range(8191), $urandom_range(3), $urandom_range(1),
                  $urandom_range(7) != 0);
         for (int i = 0; i < per_phase; i++)
            send_bin($urandom_range(1) ? $urandom_range(4095) :
                     $urandom_range(n < 4096 ? n : 4095));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      send_idle_pct = 22; recv_idle_pct = 52;
      test_random(10, 53);
      send_idle_pct = 52; recv_idle_pct = 22;
      test_random(10, 53);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(10, 53);
      req_valid <= 1'b0;
      while (pending_gains.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
rtl/core/sgm_pkg.sv
rtl/core/sgm_csr.sv
rtl/core/sgm_front.sv
rtl/core/sgm_cordic.sv
rtl/core/spectral_gain_mask_generator.sv
test/tb_top.sv
